/* design/pmg_pkg.sv */
// ============================================================================
// pmg_pkg: shared types and constants for the point-mass gravity pipeline
// Widths, stage counts and the pipeline control struct.
// ============================================================================
package pmg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;   // field width
    localparam int DW        = 33;   // |dx| magnitude width
    localparam int SW        = 67;   // dx^2+dy^2 width
    localparam int RW        = 34;   // isqrt result width
    localparam int DENW      = 101;  // d^3 width
    localparam int NUMW      = 65 + 2 * FRAC_BITS;  // mass*|dx| << 2F
    localparam int QW        = 34;   // kept quotient bits (saturation detect)
    localparam int SQ_STEPS  = RW;
    localparam int DIV_STEPS = QW;

    // configuration register indexes
    localparam logic [1:0] CFG_BODY_X = 2'd0;
    localparam logic [1:0] CFG_BODY_Y = 2'd1;
    localparam logic [1:0] CFG_MASS   = 2'd2;
    localparam logic [1:0] CFG_RADIUS = 2'd3;

    // per-item side info that travels down the pipe
    typedef struct packed {
        logic in_body;
        logic neg_x;
        logic neg_y;
    } t_side;

endpackage

/* design/point_mass_gravity_accel.sv */
// ============================================================================
// point_mass_gravity_accel: 2-D inverse-square acceleration pipeline
// Stream of probe positions in, one acceleration per probe out.
// ============================================================================
//  channel  | signals                               | dir
//  ---------+---------------------------------------+-----
//  probe    | i_valid/o_ready, i_probe_x/y          | in
//  accel    | o_valid/i_ready, o_accel_x/y, inside  | out
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data       | in
//
// One transaction accepted per cycle while the output is not stalled; the
// pipe is 5 front stages, 34 square-root steps, 3 cube stages,
// 35 divider stages and the output register.
// The whole pipe advances only when the output register is free or taken,
// so a stall freezes every stage. Reset clears valid bits and config.
// ============================================================================
module point_mass_gravity_accel
    import pmg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [W-1:0]  i_probe_x,
    input  logic signed [W-1:0]  i_probe_y,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [W-1:0]  o_accel_x_out,
    output logic signed [W-1:0]  o_accel_y_out,
    output logic                 o_inside_body,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [W-1:0]         i_cfg_data
);

    localparam int DEPTH = 5 + SQ_STEPS + 3 + DIV_STEPS + 2;

    // configuration
    logic signed [W-1:0] r_bx, r_by;
    logic [W-1:0]        r_mass, r_rad;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bx <= '0; r_by <= '0; r_mass <= '0; r_rad <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BODY_X: r_bx   <= i_cfg_data;
                CFG_BODY_Y: r_by   <= i_cfg_data;
                CFG_MASS:   r_mass <= i_cfg_data;
                CFG_RADIUS: r_rad  <= i_cfg_data;
                default:    r_bx   <= r_bx;
            endcase
        end
    end

    // global advance: pipe moves when output slot is empty or drained
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    logic [DEPTH-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[DEPTH-2:0], i_valid};
    end
    assign o_valid = r_vld[DEPTH-1];

    // stage 1: differences
    logic signed [W:0] r1_dx, r1_dy;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx <= {r_bx[W-1], r_bx} - {i_probe_x[W-1], i_probe_x};
            r1_dy <= {r_by[W-1], r_by} - {i_probe_y[W-1], i_probe_y};
        end
    end

    // stage 2: magnitudes and signs
    logic [DW-1:0] r2_ax, r2_ay;
    logic          r2_nx, r2_ny;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_nx <= r1_dx[W];
            r2_ny <= r1_dy[W];
            r2_ax <= r1_dx[W] ? DW'(-r1_dx) : DW'(r1_dx);
            r2_ay <= r1_dy[W] ? DW'(-r1_dy) : DW'(r1_dy);
        end
    end

    // stage 3: squares and radius^2
    logic [2*DW-1:0] r3_sx, r3_sy;
    logic [2*W-1:0]  r3_r2;
    logic [DW-1:0]   r3_ax, r3_ay;
    logic            r3_nx, r3_ny;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sx <= r2_ax * r2_ax;
            r3_sy <= r2_ay * r2_ay;
            r3_r2 <= r_rad * r_rad;
            r3_ax <= r2_ax; r3_ay <= r2_ay;
            r3_nx <= r2_nx; r3_ny <= r2_ny;
        end
    end

    // stage 4: sum of squares
    logic [SW-1:0]  r4_s;
    logic [2*W-1:0] r4_r2;
    logic [DW-1:0]  r4_ax, r4_ay;
    logic           r4_nx, r4_ny;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_s  <= SW'(r3_sx) + SW'(r3_sy);
            r4_r2 <= r3_r2;
            r4_ax <= r3_ax; r4_ay <= r3_ay;
            r4_nx <= r3_nx; r4_ny <= r3_ny;
        end
    end

    // stage 5: inside test
    logic [SW-1:0] r5_s;
    logic [DW-1:0] r5_ax, r5_ay;
    t_side         r5_sd;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_s  <= r4_s;
            r5_ax <= r4_ax; r5_ay <= r4_ay;
            r5_sd <= '{in_body: (r4_s == '0) || (r4_s < SW'(r4_r2)),
                       neg_x: r4_nx, neg_y: r4_ny};
        end
    end

    // square root: one result bit per stage, MSB first
    logic [SW-1:0] r_sq_s  [SQ_STEPS+1];
    logic [RW-1:0] r_sq_d  [SQ_STEPS+1];
    logic [DW-1:0] r_sq_ax [SQ_STEPS+1];
    logic [DW-1:0] r_sq_ay [SQ_STEPS+1];
    t_side         r_sq_sd [SQ_STEPS+1];
    always_comb begin
        r_sq_s[0]  = r5_s;
        r_sq_d[0]  = '0;
        r_sq_ax[0] = r5_ax;
        r_sq_ay[0] = r5_ay;
        r_sq_sd[0] = r5_sd;
    end
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        localparam int B = RW - 1 - g;
        logic [RW-1:0]   n_t;
        logic [2*RW-1:0] n_tt;
        always_comb begin
            n_t  = r_sq_d[g] | (RW'(1) << B);
            n_tt = n_t * n_t;
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_s[g+1]  <= r_sq_s[g];
                r_sq_ax[g+1] <= r_sq_ax[g];
                r_sq_ay[g+1] <= r_sq_ay[g];
                r_sq_sd[g+1] <= r_sq_sd[g];
                r_sq_d[g+1]  <= (n_tt <= (2*RW)'(r_sq_s[g])) ? n_t : r_sq_d[g];
            end
        end
    end

    // d^2 then d^3, and mass*|delta|
    logic [2*RW-1:0] r6_d2;
    logic [RW-1:0]   r6_d;
    logic [W+DW-1:0] r6_mx, r6_my;
    t_side           r6_sd;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_d2 <= r_sq_d[SQ_STEPS] * r_sq_d[SQ_STEPS];
            r6_d  <= r_sq_d[SQ_STEPS];
            r6_mx <= r_mass * r_sq_ax[SQ_STEPS];
            r6_my <= r_mass * r_sq_ay[SQ_STEPS];
            r6_sd <= r_sq_sd[SQ_STEPS];
        end
    end

    // d^3 in two halves of d^2 to keep multipliers narrow
    logic [RW+RW-1:0] r7_plo, r7_phi;
    logic [RW-1:0]    r7_d;
    logic [W+DW-1:0]  r7_mx, r7_my;
    t_side            r7_sd;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_plo <= r6_d2[RW-1:0] * r6_d;
            r7_phi <= RW'(r6_d2[2*RW-1:RW]) * r6_d;
            r7_d   <= r6_d;
            r7_mx  <= r6_mx; r7_my <= r6_my;
            r7_sd  <= r6_sd;
        end
    end

    logic [DENW-1:0] r8_den;
    logic [NUMW-1:0] r8_nx, r8_ny;
    t_side           r8_sd;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_den <= DENW'(r7_plo) + (DENW'(r7_phi) << RW);
            r8_nx  <= NUMW'(r7_mx) << (2 * FRAC_BITS);
            r8_ny  <= NUMW'(r7_my) << (2 * FRAC_BITS);
            r8_sd  <= (r7_d == '0) ? '{in_body: 1'b1, neg_x: 1'b0, neg_y: 1'b0} : r7_sd;
        end
    end

    // dividers; den forced to 1 when inside so nothing is undefined
    logic [DENW-1:0] w_den;
    assign w_den = r8_sd.in_body ? DENW'(1) : r8_den;

    logic [QW-1:0] w_qx, w_qy;
    logic          w_bx, w_by;
    pmg_div u_div_x (.i_clk, .i_en(w_en), .i_num(r8_nx), .i_den(w_den),
                     .o_q(w_qx), .o_big(w_bx));
    pmg_div u_div_y (.i_clk, .i_en(w_en), .i_num(r8_ny), .i_den(w_den),
                     .o_q(w_qy), .o_big(w_by));

    // side info follows the divider's input stage plus its quotient steps
    t_side r_dsd [DIV_STEPS+2];
    always_comb r_dsd[0] = r8_sd;
    for (genvar g = 0; g < DIV_STEPS + 1; g++) begin : g_sd
        always_ff @(posedge i_clk) begin
            if (w_en) r_dsd[g+1] <= r_dsd[g];
        end
    end

    // saturate, sign and register the output
    function automatic logic [W-1:0] f_sat(input logic [QW-1:0] q, input logic big,
                                           input logic neg);
        logic [QW-1:0] lim;
        logic [W-1:0]  m;
        lim = neg ? QW'(34'h080000000) : QW'(34'h07FFFFFFF);
        m   = (big || q > lim) ? W'(lim) : W'(q);
        return neg ? W'(-m) : m;
    endfunction

    t_side w_fsd;
    assign w_fsd = r_dsd[DIV_STEPS+1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_inside_body <= w_fsd.in_body;
            o_accel_x_out <= w_fsd.in_body ? '0 : f_sat(w_qx, w_bx, w_fsd.neg_x);
            o_accel_y_out <= w_fsd.in_body ? '0 : f_sat(w_qy, w_by, w_fsd.neg_y);
        end
    end

endmodule

/* design/pmg_div.sv */
// ============================================================================
// pmg_div: pipelined restoring divider, one quotient bit per stage
// Computes floor(num/den) when it is below 2^QW: o_big flags quotient >= 2^QW.
// ============================================================================
module pmg_div
    import pmg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUMW-1:0]   i_num,
    input  logic [DENW-1:0]   i_den,
    output logic [QW-1:0]     o_q,
    output logic              o_big
);

    localparam int RMW = DENW + 1;

    logic [RMW-1:0]  r_rem [DIV_STEPS+1];
    logic [NUMW-1:0] r_num [DIV_STEPS+1];
    logic [DENW-1:0] r_den [DIV_STEPS+1];
    logic [QW-1:0]   r_q   [DIV_STEPS+1];
    logic            r_big [DIV_STEPS+1];

    // stage 0: quotient bits above QW only matter as "too big"
    logic [NUMW+DENW-1:0] n_hi_num;
    logic [NUMW+DENW-1:0] n_hi_lim;
    always_comb begin
        n_hi_num = {{DENW{1'b0}}, i_num};
        n_hi_lim = {{NUMW{1'b0}}, i_den} << QW;
    end

    // partial remainder starts from the numerator bits above the kept quotient
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RMW'(i_num >> QW);
            r_num[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_big[0] <= (n_hi_num >= n_hi_lim);
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        localparam int B = QW - 1 - g;
        logic [RMW-1:0] n_t;
        always_comb begin
            n_t = {r_rem[g][RMW-2:0], 1'b0} | {{(RMW-1){1'b0}}, r_num[g][B]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[g+1] <= r_num[g];
                r_den[g+1] <= r_den[g];
                r_big[g+1] <= r_big[g];
                if (n_t >= {1'b0, r_den[g]}) begin
                    r_rem[g+1] <= n_t - {1'b0, r_den[g]};
                    r_q[g+1]   <= r_q[g] | (QW'(1) << B);
                end else begin
                    r_rem[g+1] <= n_t;
                    r_q[g+1]   <= r_q[g];
                end
            end
        end
    end

    assign o_q   = r_q[DIV_STEPS];
    assign o_big = r_big[DIV_STEPS];

endmodule

/* design/pmg_checker.sv */
// ============================================================================
// pmg_checker: port-level checks on the gravity pipeline
// Output handshake and result consistency.
// ============================================================================
module pmg_checker
    import pmg_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_valid,
    input logic         i_ready,
    input logic         o_ready,
    input logic [W-1:0] o_accel_x_out,
    input logic [W-1:0] o_accel_y_out,
    input logic         o_inside_body
);

    // inside results carry zero acceleration
    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_inside_body |-> o_accel_x_out == '0 && o_accel_y_out == '0)
        else $error("inside result with nonzero acceleration");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_accel_x_out))
        else $error("stalled result changed");

    // input ready follows output free
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready mismatch");

endmodule

bind point_mass_gravity_accel pmg_checker u_chk (.*);

/* tb/sv/pmg_accel_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// pmg_accel_checker: prediction and comparison for the gravity pipeline
// Watches the probe, accel and config ports, computes the expected
// acceleration of every accepted probe and compares each accepted result.
// ============================================================================
module pmg_accel_checker
    import pmg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_ready_in,
    input  logic signed [W-1:0] i_probe_x,
    input  logic signed [W-1:0] i_probe_y,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic signed [W-1:0] i_accel_x,
    input  logic signed [W-1:0] i_accel_y,
    input  logic                i_inside,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [W-1:0]        i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);

    typedef struct packed {
        logic [W-1:0] ax;
        logic [W-1:0] ay;
        logic         in_body;
    } t_accel;

    logic signed [W-1:0] body_x, body_y;
    logic [W-1:0]        body_mass, body_radius;
    t_accel              accel_q[$];

    // floor(sqrt(s)), s below 2^67
    function automatic logic [RW-1:0] isqrt67(input logic [127:0] s);
        logic [RW-1:0] d;
        logic [RW-1:0] t;
        d = '0;
        for (int b = RW - 1; b >= 0; b--) begin
            t = d | (RW'(1) << b);
            if (128'(t) * 128'(t) <= s) d = t;
        end
        return d;
    endfunction

    // one component: truncate toward zero, then saturate
    function automatic logic [W-1:0] accel_comp(input logic signed [33:0] delta,
                                                 input logic [127:0] den);
        logic         neg;
        logic [127:0] mag, q, lim;
        neg = delta < 0;
        mag = neg ? 128'(-delta) : 128'(delta);
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        q   = ((128'(body_mass) * mag) << (2 * FRAC_BITS)) / den;
        if (q > lim) q = lim;
        return neg ? W'(-q) : W'(q);
    endfunction

    function automatic t_accel predict_accel(input logic signed [W-1:0] px,
                                             input logic signed [W-1:0] py);
        t_accel              r;
        logic signed [33:0]  dx, dy;
        logic [127:0]        s, dd, adx, ady;
        dx  = 34'(body_x) - 34'(px);
        dy  = 34'(body_y) - 34'(py);
        adx = dx < 0 ? 128'(-dx) : 128'(dx);
        ady = dy < 0 ? 128'(-dy) : 128'(dy);
        s   = adx * adx + ady * ady;
        r   = '0;
        if (s == 0 || s < 128'(body_radius) * 128'(body_radius)) begin
            r.in_body = 1'b1;
        end else begin
            dd   = 128'(isqrt67(s));
            dd   = dd * dd * dd;
            r.ax = accel_comp(dx, dd);
            r.ay = accel_comp(dy, dd);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_accel exp_a;
        if (!i_rst_n) begin
            body_x      <= '0;
            body_y      <= '0;
            body_mass   <= '0;
            body_radius <= '0;
            o_errors    <= 0;
            o_pending   <= 0;
            accel_q.delete();
        end else begin
            // results first, then new probes (queue order is what matters)
            if (i_out_valid && i_out_ready) begin
                if (accel_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result at %0t", $realtime);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_a = accel_q.pop_front();
                    if (exp_a.ax !== i_accel_x || exp_a.ay !== i_accel_y ||
                        exp_a.in_body !== i_inside) begin
                        if (o_errors < 10)
                            $display("mismatch: exp %h %h %b got %h %h %b",
                                     exp_a.ax, exp_a.ay, exp_a.in_body,
                                     i_accel_x, i_accel_y, i_inside);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_ready_in) accel_q.push_back(predict_accel(i_probe_x, i_probe_y));
            o_pending <= accel_q.size();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BODY_X: body_x      <= i_cfg_data;
                    CFG_BODY_Y: body_y      <= i_cfg_data;
                    CFG_MASS:   body_mass   <= i_cfg_data;
                    CFG_RADIUS: body_radius <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

/* tb/sv/tb_point_mass_gravity_accel.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_point_mass_gravity_accel: stimulus and verdict for the gravity pipeline
// Runs several body settings with directed and random probes under random
// source gaps and sink stalls; the checker predicts and compares results.
// ============================================================================
module tb_point_mass_gravity_accel;
    import pmg_pkg::*;

    localparam int WATCHDOG = 20000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic signed [W-1:0] i_probe_x = '0, i_probe_y = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic signed [W-1:0] o_accel_x_out, o_accel_y_out;
    logic                o_inside_body;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_idx = '0;
    logic [W-1:0]        i_cfg_data = '0;
    int                  errors, pending;
    int                  idle_cycles = 0;
    logic                done = 1'b0;
    logic [W-1:0]        cur_bx, cur_by;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    point_mass_gravity_accel dut (.*);

    pmg_accel_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_probe_x, .i_probe_y,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_accel_x(o_accel_x_out), .i_accel_y(o_accel_y_out),
        .i_inside(o_inside_body), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end
    end

    // sink: per-result random stall, skipped at random for some results
    always @(posedge i_clk) begin
        int gap;
        if (i_rst_n && !done) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            repeat (gap) begin
                i_ready <= 1'b0;
                @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_body(input logic [W-1:0] bx, input logic [W-1:0] by,
                            input logic [W-1:0] mass, input logic [W-1:0] rad);
        write_reg(CFG_BODY_X, bx);
        write_reg(CFG_BODY_Y, by);
        write_reg(CFG_MASS, mass);
        write_reg(CFG_RADIUS, rad);
        cur_bx = bx;
        cur_by = by;
    endtask

    task automatic send_probe(input logic [W-1:0] px, input logic [W-1:0] py,
                              input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 19);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_probe_x <= px;
        i_probe_y <= py;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // drain, then allow the pipe to settle before touching config
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (130) @(posedge i_clk);
    endtask

    // random offset from the body: mostly near, sometimes anywhere
    function automatic logic [W-1:0] near(input logic [W-1:0] c);
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return c + $urandom_range(0, 16) - 8;
            2:       return c + ($urandom() >>> $urandom_range(8, 31));
            default: return c - ($urandom() >>> $urandom_range(12, 24));
        endcase
    endfunction

    task automatic random_phase(input int n);
        bit burst;
        for (int k = 0; k < n; k++) begin
            burst = (k % 100) < 20;
            send_probe(near(cur_bx), near(cur_by), burst);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: everything at the origin with zero mass
        send_probe(32'h0, 32'h0, 1'b0);
        send_probe(32'h0001_0000, 32'h0, 1'b0);
        drain();

        // directed: unit mass, extremes, zero distance, radius edge
        set_body(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
        send_probe(32'h0, 32'h0, 1'b0);               // zero distance
        send_probe(32'h0000_FFFF, 32'h0, 1'b0);       // just inside radius
        send_probe(32'h0001_0000, 32'h0, 1'b0);       // on the radius
        send_probe(32'hFFFF_0000, 32'h0, 1'b0);
        send_probe(32'h0, 32'h0001_0000, 1'b0);
        send_probe(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_probe(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_probe(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_probe(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        drain();
        // max mass, zero radius: saturation both signs
        set_body(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
        send_probe(32'h7FFF_FFFE, 32'h8000_0000, 1'b0);
        send_probe(32'h7FFF_FFFF, 32'h8000_0001, 1'b0);
        send_probe(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_probe(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_probe(32'h0, 32'h0, 1'b1);
        drain();
        // max radius, everything inside unless far
        set_body(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_probe(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_probe(32'h0, 32'h0, 1'b0);
        drain();

        // random phases over varied settings
        for (int p = 0; p < 8; p++) begin
            set_body($urandom(), $urandom(),
                     (p == 0) ? 32'hFFFF_FFFF : $urandom() >> $urandom_range(0, 20),
                     (p == 1) ? 32'h0 : $urandom() >> $urandom_range(8, 31));
            random_phase(100);
            drain();
        end

        done    <= 1'b1;
        i_ready <= 1'b1;
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
